// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the consistency graph block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/plcg_pkg.sv =====
// ---------------------------------------------------------------------------
// plcg_pkg
// Sizes, codes and types shared by the consistency graph modules.
// ---------------------------------------------------------------------------
package plcg_pkg;

    // Store depth and coordinate width
    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 20;
    localparam int NOISE_W    = 20;

    // Derived widths
    localparam int INDEX_W  = $clog2(MAX_POINTS);
    localparam int COUNT_W  = $clog2(MAX_POINTS + 1);
    localparam int NUM_AXES = 3;
    localparam int AXIS_W   = 2;
    localparam int VEC_W    = NUM_AXES * COORD_BITS;
    localparam int ABS_W    = COORD_BITS;          // |a - b| < 2^COORD_BITS
    localparam int PROD_W   = 2 * COORD_BITS;
    localparam int SUM_W    = 2 * COORD_BITS + 2;  // three squares
    localparam int ROOT_W   = COORD_BITS + 1;
    localparam int CMP_W    = (ROOT_W > NOISE_W + 1) ? ROOT_W : NOISE_W + 1;

    // Command codes
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef logic [VEC_W-1:0] t_vec;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_SRC_GO,
        S_SRC_SUM,
        S_SRC_ROOT_GO,
        S_SRC_ROOT,
        S_DST_GO,
        S_DST_SUM,
        S_DST_ROOT_GO,
        S_DST_ROOT,
        S_CMP,
        S_OUT
    } t_state;

endpackage

// ===== rtl/plcg_ram.sv =====
// ---------------------------------------------------------------------------
// plcg_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module plcg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/plcg_sqdist.sv =====
// ---------------------------------------------------------------------------
// plcg_sqdist
// Squared distance of two 3D points through one shared multiplier:
// one axis issued per cycle, difference / square / accumulate pipeline.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module plcg_sqdist import plcg_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_vec             i_a,
    input  t_vec             i_b,
    output logic             o_busy,
    output logic [SUM_W-1:0] o_sum
);

    localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(NUM_AXES - 1);

    logic                    r_active;
    logic [AXIS_W-1:0]       r_axis;
    logic                    r_v1;
    logic                    r_v2;
    logic [ABS_W-1:0]        r_absd;
    logic [PROD_W-1:0]       r_prod;
    logic [SUM_W-1:0]        r_acc;

    logic [COORD_BITS-1:0]   a_c;
    logic [COORD_BITS-1:0]   b_c;
    logic signed [COORD_BITS:0] diff;
    logic [COORD_BITS:0]     mag;

    // Axis select and absolute difference
    always_comb begin
        a_c  = i_a[r_axis * COORD_BITS +: COORD_BITS];
        b_c  = i_b[r_axis * COORD_BITS +: COORD_BITS];
        diff = $signed({a_c[COORD_BITS-1], a_c}) - $signed({b_c[COORD_BITS-1], b_c});
        mag  = diff[COORD_BITS] ? $unsigned(-diff) : $unsigned(diff);
    end

    // Pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_axis   <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
        end else begin
            r_v1 <= r_active;
            r_v2 <= r_v1;
            if (i_start) begin
                r_active <= 1'b1;
                r_axis   <= '0;
            end else if (r_active) begin
                r_axis <= r_axis + 1'b1;
                if (r_axis == AXIS_LAST) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    // Datapath: abs diff, square, accumulate
    always_ff @(posedge i_clk) begin
        if (r_active) begin
            r_absd <= mag[ABS_W-1:0];
        end
        if (r_v1) begin
            r_prod <= r_absd * r_absd;
        end
        if (i_start) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + SUM_W'(r_prod);
        end
    end

    assign o_busy = r_active | r_v1 | r_v2;
    assign o_sum  = r_acc;

    `ASSERT_IMPL(a_sq_no_restart, i_clk, i_rst_n, i_start, !o_busy, "sqdist started while busy")

endmodule

// ===== rtl/plcg_isqrt.sv =====
// ---------------------------------------------------------------------------
// plcg_isqrt
// Floor integer square root, two operand bits per cycle (restoring method).
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module plcg_isqrt import plcg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SUM_W-1:0]  i_operand,
    output logic              o_busy,
    output logic [ROOT_W-1:0] o_root
);

    // Highest even bit position of the operand
    localparam logic [SUM_W-1:0] BIT_TOP = {2'b01, {(SUM_W - 2){1'b0}}};

    logic [SUM_W-1:0] r_rem;
    logic [SUM_W-1:0] r_res;
    logic [SUM_W-1:0] r_bit;
    logic [SUM_W-1:0] trial;

    assign trial = r_res + r_bit;

    // Bit marker doubles as the busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= '0;
        end else if (i_start) begin
            r_bit <= BIT_TOP;
        end else if (o_busy) begin
            r_bit <= r_bit >> 2;
        end
    end

    // One root step per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_operand;
            r_res <= '0;
        end else if (o_busy) begin
            if (r_rem >= trial) begin
                r_rem <= r_rem - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
        end
    end

    assign o_busy = |r_bit;
    assign o_root = r_res[ROOT_W-1:0];

    `ASSERT_NEXT(a_rt_start_busy, i_clk, i_rst_n, i_start, o_busy, "isqrt not busy after start")

endmodule

// ===== rtl/pairwise_length_consistency_graph.sv =====
// ---------------------------------------------------------------------------
// pairwise_length_consistency_graph
// Adds 3D correspondences to a store and returns, for each new point, the
// mask of earlier points whose source and destination distances agree to
// within twice the noise bound.
// ---------------------------------------------------------------------------
//  channel  | signals                                   | role
//  ---------+-------------------------------------------+-------------------
//  input    | i_in_valid, o_in_stall, i_command, coords | command / point in
//  output   | o_out_valid, i_out_stall, index/mask/full | one row per add
//  config   | i_cfg_we, i_cfg_wdata                     | noise bound write
//
//  An add for point k works through each of the k stored points in turn:
//  a store read, two squared-distance passes on the shared multiplier, two
//  passes of the iterative square root and a compare. A dropped point goes
//  straight to the output stage; a clear empties the store with no output.
//  Reset is synchronous, active low, and empties the store; no clearing pass.
//  Input is stalled while a point is in work; a stalled output holds the
//  result and the next add waits at its end until the output register frees.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pairwise_length_consistency_graph import plcg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [NOISE_W-1:0]    i_cfg_wdata,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_command,
    input  logic [COORD_BITS-1:0] i_src_x,
    input  logic [COORD_BITS-1:0] i_src_y,
    input  logic [COORD_BITS-1:0] i_src_z,
    input  logic [COORD_BITS-1:0] i_dst_x,
    input  logic [COORD_BITS-1:0] i_dst_y,
    input  logic [COORD_BITS-1:0] i_dst_z,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [INDEX_W-1:0]    o_point_index,
    output logic [MAX_POINTS-1:0] o_neighbor_mask,
    output logic                  o_store_full
);

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_POINTS);

    t_state                r_state, n_state;
    logic [COUNT_W-1:0]    r_count, n_count;
    logic [INDEX_W-1:0]    r_idx, n_idx;
    logic [MAX_POINTS-1:0] r_mask, n_mask;
    t_vec                  r_src, n_src;
    t_vec                  r_dst, n_dst;
    logic [ROOT_W-1:0]     r_ls, n_ls;
    logic [ROOT_W-1:0]     r_gap, n_gap;
    logic                  r_full, n_full;
    logic [NOISE_W-1:0]    r_noise;
    logic                  r_out_valid, n_out_valid;
    logic [INDEX_W-1:0]    r_out_index, n_out_index;
    logic [MAX_POINTS-1:0] r_out_mask, n_out_mask;
    logic                  r_out_full, n_out_full;

    logic                  in_fire;
    logic                  out_take;
    logic                  ram_we;
    logic                  ram_re;
    logic                  use_dst;
    logic                  sq_start;
    logic                  sq_busy;
    logic [SUM_W-1:0]      sq_sum;
    logic                  rt_start;
    logic                  rt_busy;
    logic [ROOT_W-1:0]     rt_root;
    logic [2*VEC_W-1:0]    ram_rdata;
    t_vec                  rd_src;
    t_vec                  rd_dst;
    t_vec                  in_src;
    t_vec                  in_dst;
    t_vec                  sq_a;
    t_vec                  sq_b;
    logic [CMP_W-1:0]      beta;

    assign in_src = {i_src_z, i_src_y, i_src_x};
    assign in_dst = {i_dst_z, i_dst_y, i_dst_x};
    assign rd_src = ram_rdata[VEC_W-1:0];
    assign rd_dst = ram_rdata[2*VEC_W-1:VEC_W];
    assign beta   = CMP_W'({r_noise, 1'b0});

    assign o_in_stall = (r_state != S_IDLE);
    assign in_fire    = i_in_valid && (r_state == S_IDLE);
    assign out_take   = r_out_valid && !i_out_stall;

    // Point store: source and destination coordinates side by side
    plcg_ram #(
        .WIDTH (2 * VEC_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[INDEX_W-1:0]),
        .i_wdata ({in_dst, in_src}),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // Shared squared-distance unit
    assign sq_a = use_dst ? r_dst : r_src;
    assign sq_b = use_dst ? rd_dst : rd_src;

    plcg_sqdist u_sqdist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_a     (sq_a),
        .i_b     (sq_b),
        .o_busy  (sq_busy),
        .o_sum   (sq_sum)
    );

    // Shared square root unit
    plcg_isqrt u_isqrt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (rt_start),
        .i_operand (sq_sum),
        .o_busy    (rt_busy),
        .o_root    (rt_root)
    );

    // Sequencer: next state, strobes and register updates
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_mask      = r_mask;
        n_src       = r_src;
        n_dst       = r_dst;
        n_ls        = r_ls;
        n_gap       = r_gap;
        n_full      = r_full;
        n_out_valid = out_take ? 1'b0 : r_out_valid;
        n_out_index = r_out_index;
        n_out_mask  = r_out_mask;
        n_out_full  = r_out_full;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        use_dst     = 1'b0;
        sq_start    = 1'b0;
        rt_start    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_command == CMD_CLEAR) begin
                        n_count = '0;
                    end else if (r_count >= COUNT_MAX) begin
                        n_full  = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        ram_we  = 1'b1;
                        n_full  = 1'b0;
                        n_src   = in_src;
                        n_dst   = in_dst;
                        n_idx   = '0;
                        n_mask  = '0;
                        n_state = (r_count == '0) ? S_OUT : S_READ;
                    end
                end
            end
            S_READ: begin
                ram_re  = 1'b1;
                n_state = S_SRC_GO;
            end
            S_SRC_GO: begin
                sq_start = 1'b1;
                n_state  = S_SRC_SUM;
            end
            S_SRC_SUM: begin
                if (!sq_busy) begin
                    n_state = S_SRC_ROOT_GO;
                end
            end
            S_SRC_ROOT_GO: begin
                rt_start = 1'b1;
                n_state  = S_SRC_ROOT;
            end
            S_SRC_ROOT: begin
                if (!rt_busy) begin
                    n_ls    = rt_root;
                    n_state = S_DST_GO;
                end
            end
            S_DST_GO: begin
                use_dst  = 1'b1;
                sq_start = 1'b1;
                n_state  = S_DST_SUM;
            end
            S_DST_SUM: begin
                use_dst = 1'b1;
                if (!sq_busy) begin
                    n_state = S_DST_ROOT_GO;
                end
            end
            S_DST_ROOT_GO: begin
                rt_start = 1'b1;
                n_state  = S_DST_ROOT;
            end
            S_DST_ROOT: begin
                if (!rt_busy) begin
                    n_gap   = (r_ls >= rt_root) ? (r_ls - rt_root) : (rt_root - r_ls);
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                // pair is consistent when the length gap is within 2*noise
                if (CMP_W'(r_gap) <= beta) begin
                    n_mask[r_idx] = 1'b1;
                end
                n_idx = r_idx + 1'b1;
                if (COUNT_W'(r_idx) + 1'b1 == r_count) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_READ;
                end
            end
            S_OUT: begin
                // wait for the output register to free up
                if (!r_out_valid || out_take) begin
                    n_out_valid = 1'b1;
                    n_out_full  = r_full;
                    n_out_index = r_full ? '0 : r_count[INDEX_W-1:0];
                    n_out_mask  = r_full ? '0 : r_mask;
                    if (!r_full) begin
                        n_count = r_count + 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_noise     <= '0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_noise <= i_cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_mask      <= n_mask;
        r_src       <= n_src;
        r_dst       <= n_dst;
        r_ls        <= n_ls;
        r_gap       <= n_gap;
        r_full      <= n_full;
        r_out_index <= n_out_index;
        r_out_mask  <= n_out_mask;
        r_out_full  <= n_out_full;
    end

    assign o_out_valid     = r_out_valid;
    assign o_point_index   = r_out_index;
    assign o_neighbor_mask = r_out_mask;
    assign o_store_full    = r_out_full;

    `ASSERT_IMPL(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= COUNT_MAX, "point count overflow")
    `ASSERT_IMPL(a_full_empty_row, i_clk, i_rst_n, o_out_valid && o_store_full, (o_neighbor_mask == '0) && (o_point_index == '0), "full result carries data")
    `ASSERT_IMPL(a_mask_below_index, i_clk, i_rst_n, o_out_valid && !o_store_full, (o_neighbor_mask >> o_point_index) == '0, "mask bit at or above own index")

endmodule
